FILE: src/assert_macros.svh
// Assertion macros shared by the congestion window RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every edge out of reset.
`define TCW_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Same-cycle implication.
`define TCW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication failed");

// Next-cycle implication.
`define TCW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

FILE: src/tcwnd_pkg.sv
// Types, constants, helpers and microcode program of the congestion window block.
package tcwnd_pkg;

    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);
    localparam int unsigned STEP_W    = 5;

    localparam logic [7:0] DUP_TRIGGER = 8'd3;
    localparam logic [7:0] DUP_MAX     = 8'd255;

    localparam logic [1:0] PH_SLOW    = 2'd0;
    localparam logic [1:0] PH_AVOID   = 2'd1;
    localparam logic [1:0] PH_RETX    = 2'd2;
    localparam logic [1:0] PH_RECOVER = 2'd3;

    localparam logic [1:0] CFG_SEG_SIZE     = 2'd0;
    localparam logic [1:0] CFG_INIT_WINDOW  = 2'd1;
    localparam logic [1:0] CFG_INIT_THRESH  = 2'd2;
    localparam logic [1:0] CFG_INIT_SEQ     = 2'd3;

    localparam logic [15:0] RST_SEG_SIZE    = 16'd1460;
    localparam logic [31:0] RST_INIT_WINDOW = 32'd4380;
    localparam logic [31:0] RST_INIT_THRESH = 32'd65535;
    localparam logic [31:0] RST_INIT_SEQ    = 32'd0;

    // program addresses
    localparam logic [STEP_W-1:0] ST_IDLE       = 5'd0;
    localparam logic [STEP_W-1:0] ST_DECODE     = 5'd1;
    localparam logic [STEP_W-1:0] ST_ACK        = 5'd2;
    localparam logic [STEP_W-1:0] ST_CHK_REC    = 5'd3;
    localparam logic [STEP_W-1:0] ST_CHK_DUP3   = 5'd4;
    localparam logic [STEP_W-1:0] ST_CHK_DUPM   = 5'd5;
    localparam logic [STEP_W-1:0] ST_CHK_BELOW  = 5'd6;
    localparam logic [STEP_W-1:0] ST_SQUARE     = 5'd7;
    localparam logic [STEP_W-1:0] ST_DIV        = 5'd8;
    localparam logic [STEP_W-1:0] ST_AVOID      = 5'd9;
    localparam logic [STEP_W-1:0] ST_REC_EXIT   = 5'd10;
    localparam logic [STEP_W-1:0] ST_RETX_THR   = 5'd11;
    localparam logic [STEP_W-1:0] ST_RETX_WIN   = 5'd12;
    localparam logic [STEP_W-1:0] ST_INFLATE    = 5'd13;
    localparam logic [STEP_W-1:0] ST_SLOW       = 5'd14;
    localparam logic [STEP_W-1:0] ST_RESTART    = 5'd15;
    localparam logic [STEP_W-1:0] ST_EMIT       = 5'd16;
    localparam logic [STEP_W-1:0] ST_EMIT_RETRY = 5'd17;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACK,
        OP_SQUARE,
        OP_DIV_STEP,
        OP_AVOID,
        OP_REC_EXIT,
        OP_RETX_THR,
        OP_RETX_WIN,
        OP_INFLATE,
        OP_SLOW,
        OP_RESTART,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_IDLE,
        C_RESTART,
        C_NEW_IN_REC,
        C_DUP3,
        C_DUP_MORE,
        C_BELOW,
        C_DIV_MORE,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic        func;
        logic [31:0] ack_num;
        logic [31:0] send_next;
    } t_in_item;

    typedef struct packed {
        logic        retransmit;
        logic        ack_accepted;
        logic [31:0] window_out;
        logic [31:0] threshold_out;
        logic [1:0]  phase_out;
        logic [31:0] unacked_out;
        logic [7:0]  dup_out;
    } t_out_item;

    typedef struct packed {
        logic [15:0] seg_size;
        logic [31:0] initial_window;
        logic [31:0] initial_threshold;
        logic [31:0] initial_sequence;
    } t_cfg;

    typedef struct packed {
        logic restart;
        logic new_in_rec;
        logic dup3;
        logic dup_more;
        logic below;
        logic div_more;
    } t_dp_status;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // The window program. A word jumps to its target when its condition holds.
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        case (step)
            ST_IDLE:       ucode = '{OP_NOP,      C_IDLE,       ST_IDLE};
            ST_DECODE:     ucode = '{OP_NOP,      C_RESTART,    ST_RESTART};
            ST_ACK:        ucode = '{OP_ACK,      C_NEVER,      ST_IDLE};
            ST_CHK_REC:    ucode = '{OP_NOP,      C_NEW_IN_REC, ST_REC_EXIT};
            ST_CHK_DUP3:   ucode = '{OP_NOP,      C_DUP3,       ST_RETX_THR};
            ST_CHK_DUPM:   ucode = '{OP_NOP,      C_DUP_MORE,   ST_INFLATE};
            ST_CHK_BELOW:  ucode = '{OP_NOP,      C_BELOW,      ST_SLOW};
            ST_SQUARE:     ucode = '{OP_SQUARE,   C_NEVER,      ST_IDLE};
            ST_DIV:        ucode = '{OP_DIV_STEP, C_DIV_MORE,   ST_DIV};
            ST_AVOID:      ucode = '{OP_AVOID,    C_ALWAYS,     ST_EMIT};
            ST_REC_EXIT:   ucode = '{OP_REC_EXIT, C_ALWAYS,     ST_EMIT};
            ST_RETX_THR:   ucode = '{OP_RETX_THR, C_NEVER,      ST_IDLE};
            ST_RETX_WIN:   ucode = '{OP_RETX_WIN, C_ALWAYS,     ST_EMIT};
            ST_INFLATE:    ucode = '{OP_INFLATE,  C_ALWAYS,     ST_EMIT};
            ST_SLOW:       ucode = '{OP_SLOW,     C_ALWAYS,     ST_EMIT};
            ST_RESTART:    ucode = '{OP_RESTART,  C_NEVER,      ST_IDLE};
            ST_EMIT:       ucode = '{OP_EMIT,     C_OUT_FREE,   ST_IDLE};
            ST_EMIT_RETRY: ucode = '{OP_NOP,      C_ALWAYS,     ST_EMIT};
            default:       ucode = '{OP_NOP,      C_ALWAYS,     ST_IDLE};
        endcase
    endfunction

endpackage

FILE: src/tcwnd_seq.sv
// Microcode sequencer: step counter, program lookup and conditional jumps.
module tcwnd_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tcwnd_pkg::t_dp_status       i_status,
    input  logic                        i_pending,
    input  logic                        i_out_blocked,
    output tcwnd_pkg::t_op              o_op,
    output logic                        o_idle
);

    logic [tcwnd_pkg::STEP_W-1:0] r_step;
    logic [tcwnd_pkg::STEP_W-1:0] n_step;
    tcwnd_pkg::t_uword            uw;
    logic                         take;

    assign uw = tcwnd_pkg::ucode(r_step);

    always_comb begin
        unique case (uw.cond)
            tcwnd_pkg::C_NEVER:      take = 1'b0;
            tcwnd_pkg::C_ALWAYS:     take = 1'b1;
            tcwnd_pkg::C_IDLE:       take = !i_pending;
            tcwnd_pkg::C_RESTART:    take = i_status.restart;
            tcwnd_pkg::C_NEW_IN_REC: take = i_status.new_in_rec;
            tcwnd_pkg::C_DUP3:       take = i_status.dup3;
            tcwnd_pkg::C_DUP_MORE:   take = i_status.dup_more;
            tcwnd_pkg::C_BELOW:      take = i_status.below;
            tcwnd_pkg::C_DIV_MORE:   take = i_status.div_more;
            tcwnd_pkg::C_OUT_FREE:   take = !i_out_blocked;
            default:                 take = 1'b0;
        endcase
        n_step = take ? uw.target : r_step + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= tcwnd_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_op   = uw.op;
    assign o_idle = (r_step == tcwnd_pkg::ST_IDLE);

endmodule

FILE: src/tcwnd_dp.sv
// Datapath: connection state, window arithmetic and the restoring divider.
module tcwnd_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  tcwnd_pkg::t_in_item     i_in,
    input  tcwnd_pkg::t_cfg         i_cfg,
    input  tcwnd_pkg::t_op          i_op,
    output tcwnd_pkg::t_dp_status   o_status,
    output tcwnd_pkg::t_out_item    o_result
);

    // held item
    logic        r_func;
    logic [31:0] r_ack;
    logic [31:0] r_nxt;

    // connection state
    logic [31:0] r_una,   n_una;
    logic [31:0] r_dseq,  n_dseq;
    logic [7:0]  r_dcnt,  n_dcnt;
    logic [31:0] r_cwnd,  n_cwnd;
    logic [31:0] r_thr,   n_thr;
    logic [1:0]  r_phase, n_phase;
    logic        r_retx,  n_retx;
    logic        r_acc,   n_acc;

    // scratch and divider
    logic [31:0]                     r_acked, n_acked;
    logic [31:0]                     r_quo,   n_quo;
    logic [31:0]                     r_rem,   n_rem;
    logic [31:0]                     r_div,   n_div;
    logic [tcwnd_pkg::DIV_CNT_W-1:0] r_cnt,   n_cnt;

    logic [32:0] shifted;
    logic [32:0] diff;
    logic        ge;
    logic [31:0] seg32;
    logic [31:0] span;
    logic [31:0] half;
    logic [31:0] two_seg;
    logic [31:0] three_seg;

    assign seg32     = {16'd0, i_cfg.seg_size};
    assign span      = r_nxt - r_una;
    assign half      = {1'b0, span[31:1]};
    assign two_seg   = {15'd0, i_cfg.seg_size, 1'b0};
    assign three_seg = two_seg + seg32;

    assign shifted = {r_rem, r_quo[31]};
    assign diff    = shifted - {1'b0, r_div};
    assign ge      = !diff[32];

    always_comb begin
        n_una   = r_una;
        n_dseq  = r_dseq;
        n_dcnt  = r_dcnt;
        n_cwnd  = r_cwnd;
        n_thr   = r_thr;
        n_phase = r_phase;
        n_retx  = r_retx;
        n_acc   = r_acc;
        n_acked = r_acked;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_div   = r_div;
        n_cnt   = r_cnt;
        unique case (i_op)
            tcwnd_pkg::OP_ACK: begin
                n_retx  = 1'b0;
                n_acc   = 1'b0;
                n_acked = r_ack - r_una;
                if (r_ack > r_una && r_ack <= r_nxt) begin
                    n_acc  = 1'b1;
                    n_dcnt = '0;
                    n_una  = r_ack;
                end else if (r_ack == r_una) begin
                    if (r_ack > r_dseq) begin
                        n_dseq = r_ack;
                        n_dcnt = 8'd1;
                    end else if (r_ack == r_dseq && r_dcnt != tcwnd_pkg::DUP_MAX) begin
                        n_dcnt = r_dcnt + 8'd1;
                    end
                end
            end
            tcwnd_pkg::OP_SQUARE: begin
                n_quo = 32'(i_cfg.seg_size) * 32'(i_cfg.seg_size);
                n_rem = '0;
                n_div = (r_cwnd == '0) ? 32'd1 : r_cwnd;
                n_cnt = tcwnd_pkg::DIV_CNT_W'(tcwnd_pkg::DIV_STEPS);
            end
            tcwnd_pkg::OP_DIV_STEP: begin
                n_rem = ge ? diff[31:0] : shifted[31:0];
                n_quo = {r_quo[30:0], ge};
                n_cnt = r_cnt - 1'b1;
            end
            tcwnd_pkg::OP_AVOID: begin
                n_phase = tcwnd_pkg::PH_AVOID;
                n_cwnd  = tcwnd_pkg::sat_add(r_cwnd, (r_quo == '0) ? 32'd1 : r_quo);
            end
            tcwnd_pkg::OP_REC_EXIT: begin
                n_dcnt  = '0;
                n_phase = tcwnd_pkg::PH_AVOID;
                n_cwnd  = r_thr;
            end
            tcwnd_pkg::OP_RETX_THR: begin
                n_phase = tcwnd_pkg::PH_RETX;
                n_retx  = 1'b1;
                n_thr   = (half > two_seg) ? half : two_seg;
            end
            tcwnd_pkg::OP_RETX_WIN: begin
                n_cwnd = tcwnd_pkg::sat_add(r_thr, three_seg);
            end
            tcwnd_pkg::OP_INFLATE: begin
                n_phase = tcwnd_pkg::PH_RECOVER;
                n_cwnd  = tcwnd_pkg::sat_add(r_cwnd, seg32);
            end
            tcwnd_pkg::OP_SLOW: begin
                n_phase = tcwnd_pkg::PH_SLOW;
                n_cwnd  = tcwnd_pkg::sat_add(r_cwnd, (r_acked < seg32) ? r_acked : seg32);
            end
            tcwnd_pkg::OP_RESTART: begin
                n_una   = i_cfg.initial_sequence;
                n_cwnd  = i_cfg.initial_window;
                n_thr   = i_cfg.initial_threshold;
                n_dseq  = '0;
                n_dcnt  = '0;
                n_phase = tcwnd_pkg::PH_SLOW;
                n_retx  = 1'b0;
                n_acc   = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_una   <= '0;
            r_dseq  <= '0;
            r_dcnt  <= '0;
            r_cwnd  <= tcwnd_pkg::RST_INIT_WINDOW;
            r_thr   <= tcwnd_pkg::RST_INIT_THRESH;
            r_phase <= tcwnd_pkg::PH_SLOW;
            r_retx  <= 1'b0;
            r_acc   <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_una   <= n_una;
            r_dseq  <= n_dseq;
            r_dcnt  <= n_dcnt;
            r_cwnd  <= n_cwnd;
            r_thr   <= n_thr;
            r_phase <= n_phase;
            r_retx  <= n_retx;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acked <= n_acked;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_div   <= n_div;
        if (i_load) begin
            r_func <= i_in.func;
            r_ack  <= i_in.ack_num;
            r_nxt  <= i_in.send_next;
        end
    end

    assign o_status.restart    = r_func;
    assign o_status.new_in_rec = r_acc && (r_phase == tcwnd_pkg::PH_RECOVER);
    assign o_status.dup3       = (r_dcnt == tcwnd_pkg::DUP_TRIGGER);
    assign o_status.dup_more   = (r_dcnt > tcwnd_pkg::DUP_TRIGGER);
    assign o_status.below      = (r_cwnd < r_thr);
    assign o_status.div_more   = (r_cnt != tcwnd_pkg::DIV_CNT_W'(1));

    assign o_result.retransmit    = r_retx;
    assign o_result.ack_accepted  = r_acc;
    assign o_result.window_out    = r_cwnd;
    assign o_result.threshold_out = r_thr;
    assign o_result.phase_out     = r_phase;
    assign o_result.unacked_out   = r_una;
    assign o_result.dup_out       = r_dcnt;

endmodule

FILE: src/tcp_ack_congestion_window_top.sv
// Top level of the Reno congestion window block: handshakes, registers, sequencer, datapath.
// Path, accept to result valid: restart goes straight to the emit word; other items run the ack
//   checks, then recovery exit, retransmit, inflation, slow start or the 32-step restoring divider.
// Items: one at a time, the next taken the cycle after its result is registered;
//   a stalled result holds the program in a retry loop between the emit and retry words.
// Reset (synchronous, active low): registers to defaults, window 4380, threshold 65535, idle.
`include "assert_macros.svh"

module tcp_ack_congestion_window_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input item channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  tcwnd_pkg::t_in_item   i_in_data,
    // result item channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output tcwnd_pkg::t_out_item  o_out_data,
    // register write port
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [31:0]           i_cfg_data
);

    // Configuration registers. Write them only while the block is idle; the block does not enforce it.
    tcwnd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seg_size          <= tcwnd_pkg::RST_SEG_SIZE;
            r_cfg.initial_window    <= tcwnd_pkg::RST_INIT_WINDOW;
            r_cfg.initial_threshold <= tcwnd_pkg::RST_INIT_THRESH;
            r_cfg.initial_sequence  <= tcwnd_pkg::RST_INIT_SEQ;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tcwnd_pkg::CFG_SEG_SIZE:    r_cfg.seg_size          <= i_cfg_data[15:0];
                tcwnd_pkg::CFG_INIT_WINDOW: r_cfg.initial_window    <= i_cfg_data;
                tcwnd_pkg::CFG_INIT_THRESH: r_cfg.initial_threshold <= i_cfg_data;
                tcwnd_pkg::CFG_INIT_SEQ:    r_cfg.initial_sequence  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // r_busy: an item is held in the datapath and its result not yet emitted.
    // The input side stalls only on that, never on the output register, so a new
    // item goes in while the previous result waits to be taken.
    logic                   r_busy, n_busy;
    logic                   r_out_valid, n_out_valid;
    tcwnd_pkg::t_out_item   r_out;

    logic                   in_acc;
    logic                   out_blocked;
    logic                   do_emit;
    logic                   seq_idle;
    tcwnd_pkg::t_op         op;
    tcwnd_pkg::t_dp_status  status;
    tcwnd_pkg::t_out_item   result;

    assign o_in_stall  = r_busy;
    assign in_acc      = i_in_valid && !r_busy;
    assign out_blocked = r_out_valid && i_out_stall;
    // The emit word retries through the program until the output register frees.
    assign do_emit     = (op == tcwnd_pkg::OP_EMIT) && !out_blocked;

    always_comb begin
        n_busy = r_busy;
        if (do_emit) begin
            n_busy = 1'b0;
        end else if (in_acc) begin
            n_busy = 1'b1;
        end
        n_out_valid = do_emit ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Program sequencer: walks the control words, branching on datapath status.
    tcwnd_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_status      (status),
        .i_pending     (r_busy),
        .i_out_blocked (out_blocked),
        .o_op          (op),
        .o_idle        (seq_idle)
    );

    // Datapath: sequence tracking, window rules, divider for the avoidance step.
    tcwnd_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_acc),
        .i_in     (i_in_data),
        .i_cfg    (r_cfg),
        .i_op     (op),
        .o_status (status),
        .o_result (result)
    );

    // Checks
    `TCW_ASSERT_IMP(a_accept_when_idle, i_clk, i_rst_n, in_acc, seq_idle)
    `TCW_ASSERT_IMP(a_emit_needs_item, i_clk, i_rst_n, do_emit, r_busy)
    `TCW_ASSERT_NEXT(a_emit_fills_out, i_clk, i_rst_n, do_emit, r_out_valid && !r_busy)
    `TCW_ASSERT(a_retx_phase, i_clk, i_rst_n, !r_out_valid || !r_out.retransmit || (r_out.phase_out == tcwnd_pkg::PH_RETX))

endmodule
